### hdl/i2cmrr_pkg.sv
// ----------------------------------------------------------------------------
// i2cmrr_pkg
// shared types and constants of the i2c master register read core
// ----------------------------------------------------------------------------
package i2cmrr_pkg;

  // request kinds carried by an input beat
  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_START = 1'b1
  } req_e;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_BIT_PHASE      = 2'd2;
  localparam logic [1:0] REG_START_STOP     = 2'd3;

  // register reset values
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'h69;
  localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;
  localparam logic [3:0] BIT_PHASE_RST      = 4'd2;
  localparam logic [3:0] START_STOP_RST     = 4'd4;

  // queue depth between front and engine
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // classified input beat
  typedef struct packed {
    req_e       kind;
    logic [7:0] reg_addr;
    logic [7:0] read_length;
    logic       sda_in;
  } item_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] ack_timeout_limit;
    logic [3:0] bit_phase_ticks;
    logic [3:0] start_stop_ticks;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       data_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       busy_res;
    logic       error;
  } result_t;

  // phase timer step: done flag and next tick count
  typedef struct packed {
    logic       done;
    logic [3:0] count;
  } phase_t;

  function automatic phase_t phase_step(input logic [3:0] count, input logic [3:0] len);
    logic [3:0] n;
    logic [3:0] t;
    phase_t     r;
    n = (len == 4'd0) ? 4'd1 : len;
    t = count + 4'd1;
    r.done  = (t >= n);
    r.count = r.done ? 4'd0 : t;
    return r;
  endfunction

endpackage

### hdl/i2cmrr_front.sv
// ----------------------------------------------------------------------------
// i2cmrr_front
// accepts input beats, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module i2cmrr_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [7:0]         reg_addr_i,
  input  logic [7:0]         read_length_i,
  input  logic               sda_in_i,
  output logic               q_valid_o,
  output i2cmrr_pkg::item_t  q_item_o,
  input  logic               q_pop_i
);

  i2cmrr_pkg::item_t                          slot_q [i2cmrr_pkg::QueueDepth];
  logic [i2cmrr_pkg::QueuePtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [i2cmrr_pkg::QueuePtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [i2cmrr_pkg::QueueCntW-1:0]           count_q, count_d;
  i2cmrr_pkg::item_t                          item_in;
  logic                                       push;
  logic                                       pop;

  // classify the incoming beat
  always_comb begin
    item_in.kind        = req_type_i ? i2cmrr_pkg::REQ_START : i2cmrr_pkg::REQ_TICK;
    item_in.reg_addr    = reg_addr_i;
    item_in.read_length = read_length_i;
    item_in.sda_in      = sda_in_i;
  end

  assign in_ready_o = (count_q != i2cmrr_pkg::QueueCntW'(i2cmrr_pkg::QueueDepth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == i2cmrr_pkg::QueuePtrW'(i2cmrr_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == i2cmrr_pkg::QueuePtrW'(i2cmrr_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

### hdl/i2cmrr_engine.sv
// ----------------------------------------------------------------------------
// i2cmrr_engine
// bus sequencer: one step per queued beat, result held in an output register
// ----------------------------------------------------------------------------
module i2cmrr_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2cmrr_pkg::cfg_t     cfg_i,
  input  logic                 q_valid_i,
  input  i2cmrr_pkg::item_t    q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output i2cmrr_pkg::result_t  result_o
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START1    = 5'd1,
    ST_START2    = 5'd2,
    ST_DEV_LOW   = 5'd3,
    ST_DEV_HIGH  = 5'd4,
    ST_REG_LOW   = 5'd5,
    ST_REG_HIGH  = 5'd6,
    ST_ACKD_LOW  = 5'd7,
    ST_ACKD_HIGH = 5'd8,
    ST_ACKR_LOW  = 5'd9,
    ST_ACKR_HIGH = 5'd10,
    ST_RS_LOW    = 5'd11,
    ST_RX_LOW    = 5'd12,
    ST_RX_HIGH   = 5'd13,
    ST_MACK_LOW  = 5'd14,
    ST_MACK_HIGH = 5'd15,
    ST_STOP1     = 5'd16,
    ST_STOP2     = 5'd17,
    ST_STOP3     = 5'd18
  } state_e;

  state_e              state_q, state_d;
  logic [3:0]          tick_q, tick_d;
  logic [3:0]          bit_q, bit_d;
  logic [7:0]          shift_q, shift_d;
  logic [7:0]          left_q, left_d;
  logic [7:0]          held_addr_q, held_addr_d;
  logic [7:0]          ack_wait_q, ack_wait_d;
  logic                error_q, error_d;
  logic                pass_q, pass_d;
  logic                out_valid_q;
  i2cmrr_pkg::result_t res_q, res_d;
  i2cmrr_pkg::phase_t  bit_ph;
  i2cmrr_pkg::phase_t  ss_ph;
  logic [7:0]          rx_shift;
  logic [3:0]          bit_inc;
  logic [7:0]          left_dec;

  // take a beat when the output register is free or being drained
  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign bit_ph   = i2cmrr_pkg::phase_step(tick_q, cfg_i.bit_phase_ticks);
  assign ss_ph    = i2cmrr_pkg::phase_step(tick_q, cfg_i.start_stop_ticks);
  assign rx_shift = (tick_q == 4'd0) ? {shift_q[6:0], q_item_i.sda_in} : shift_q;
  assign bit_inc  = bit_q + 4'd1;
  assign left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

  // next step of the sequencer
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    left_d      = left_q;
    held_addr_d = held_addr_q;
    ack_wait_d  = ack_wait_q;
    error_d     = error_q;
    pass_d      = pass_q;
    res_d       = '0;

    if (q_item_i.kind == i2cmrr_pkg::REQ_START) begin
      // start request only latches when the bus is idle
      if (state_q == ST_IDLE) begin
        held_addr_d = q_item_i.reg_addr;
        left_d      = q_item_i.read_length;
        error_d     = 1'b0;
        pass_d      = 1'b0;
        bit_d       = 4'd0;
        shift_d     = 8'd0;
        ack_wait_d  = 8'd0;
        state_d     = ST_START1;
        tick_d      = 4'd0;
      end
    end else begin
      unique case (state_q)
        ST_START1: begin
          tick_d = ss_ph.count;
          if (ss_ph.done) state_d = ST_START2;
        end
        ST_START2: begin
          tick_d = ss_ph.count;
          if (ss_ph.done) begin
            shift_d = {cfg_i.device_address, pass_q};
            bit_d   = 4'd0;
            state_d = ST_DEV_LOW;
          end
        end
        ST_DEV_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_DEV_HIGH;
        end
        ST_REG_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_REG_HIGH;
        end
        ST_DEV_HIGH, ST_REG_HIGH: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) begin
            shift_d = {shift_q[6:0], 1'b0};
            bit_d   = bit_inc;
            if (bit_inc >= 4'd8) begin
              state_d    = (state_q == ST_DEV_HIGH) ? ST_ACKD_LOW : ST_ACKR_LOW;
              bit_d      = 4'd0;
              ack_wait_d = 8'd0;
            end else begin
              state_d = (state_q == ST_DEV_HIGH) ? ST_DEV_LOW : ST_REG_LOW;
            end
          end
        end
        ST_ACKD_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_ACKD_HIGH;
        end
        ST_ACKR_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_ACKR_HIGH;
        end
        ST_ACKD_HIGH, ST_ACKR_HIGH: begin
          if (!q_item_i.sda_in) begin
            tick_d = 4'd0;
            if (state_q == ST_ACKR_HIGH) begin
              pass_d  = 1'b1;
              state_d = ST_RS_LOW;
            end else if (!pass_q) begin
              shift_d = held_addr_q;
              bit_d   = 4'd0;
              state_d = ST_REG_LOW;
            end else if (left_q == 8'd0) begin
              state_d = ST_STOP1;
            end else begin
              shift_d = 8'd0;
              bit_d   = 4'd0;
              state_d = ST_RX_LOW;
            end
          end else if (ack_wait_q >= cfg_i.ack_timeout_limit) begin
            // acknowledge missing too long: abort with a stop
            error_d = 1'b1;
            state_d = ST_STOP1;
            tick_d  = 4'd0;
          end else begin
            ack_wait_d = ack_wait_q + 8'd1;
          end
        end
        ST_RS_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_START1;
        end
        ST_RX_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_RX_HIGH;
        end
        ST_RX_HIGH: begin
          // data bit sampled on the first tick of the high phase
          shift_d = rx_shift;
          tick_d  = bit_ph.count;
          if (bit_ph.done) begin
            bit_d = bit_inc;
            if (bit_inc >= 4'd8) begin
              res_d.data_valid = 1'b1;
              res_d.read_byte  = rx_shift;
              res_d.last_byte  = (left_q <= 8'd1);
              bit_d            = 4'd0;
              state_d          = ST_MACK_LOW;
            end else begin
              state_d = ST_RX_LOW;
            end
          end
        end
        ST_MACK_LOW: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) state_d = ST_MACK_HIGH;
        end
        ST_MACK_HIGH: begin
          tick_d = bit_ph.count;
          if (bit_ph.done) begin
            left_d = left_dec;
            if (left_dec == 8'd0) begin
              state_d = ST_STOP1;
            end else begin
              shift_d = 8'd0;
              bit_d   = 4'd0;
              state_d = ST_RX_LOW;
            end
          end
        end
        ST_STOP1: begin
          tick_d = ss_ph.count;
          if (ss_ph.done) state_d = ST_STOP2;
        end
        ST_STOP2: begin
          tick_d = ss_ph.count;
          if (ss_ph.done) state_d = ST_STOP3;
        end
        ST_STOP3: begin
          tick_d = ss_ph.count;
          if (ss_ph.done) state_d = ST_IDLE;
        end
        default: begin
          state_d = ST_IDLE;
          tick_d  = 4'd0;
        end
      endcase
    end

    // line levels after this step
    unique case (state_d)
      ST_START2: begin
        res_d.scl_level = 1'b1; res_d.sda_release = 1'b0;
      end
      ST_DEV_LOW, ST_REG_LOW: begin
        res_d.scl_level = 1'b0; res_d.sda_release = shift_d[7];
      end
      ST_DEV_HIGH, ST_REG_HIGH: begin
        res_d.scl_level = 1'b1; res_d.sda_release = shift_d[7];
      end
      ST_ACKD_LOW, ST_ACKR_LOW, ST_RS_LOW, ST_RX_LOW: begin
        res_d.scl_level = 1'b0; res_d.sda_release = 1'b1;
      end
      ST_MACK_LOW: begin
        res_d.scl_level = 1'b0; res_d.sda_release = (left_d <= 8'd1);
      end
      ST_MACK_HIGH: begin
        res_d.scl_level = 1'b1; res_d.sda_release = (left_d <= 8'd1);
      end
      ST_STOP1: begin
        res_d.scl_level = 1'b0; res_d.sda_release = 1'b0;
      end
      ST_STOP2: begin
        res_d.scl_level = 1'b1; res_d.sda_release = 1'b0;
      end
      default: begin
        res_d.scl_level = 1'b1; res_d.sda_release = 1'b1;
      end
    endcase
    res_d.busy_res = (state_d != ST_IDLE);
    res_d.error    = error_d;
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= 4'd0;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      left_q      <= 8'd0;
      held_addr_q <= 8'd0;
      ack_wait_q  <= 8'd0;
      error_q     <= 1'b0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (q_pop_o) begin
        state_q     <= state_d;
        tick_q      <= tick_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        left_q      <= left_d;
        held_addr_q <= held_addr_d;
        ack_wait_q  <= ack_wait_d;
        error_q     <= error_d;
        pass_q      <= pass_d;
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### hdl/i2c_master_register_read_core.sv
// ----------------------------------------------------------------------------
// i2c_master_register_read_core
// i2c master engine for register reads, stepped one tick beat at a time
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i/in_ready_o): each beat is either a start
//   request (req_type_i = 1, with reg_addr_i and read_length_i) or one
//   microsecond tick carrying the sampled SDA level in sda_in_i.
//   output channel (out_valid_o/out_ready_i): exactly one result beat per
//   input beat, in order, with SCL/SDA levels, a received byte when
//   data_valid_o is set, busy and error status.
//   configuration: apb-style write/read port, registers at 0x0 device
//   address, 0x4 ack timeout, 0x8 bit phase ticks, 0xc start/stop ticks;
//   write them only while the core is idle.
// timing:
//   a beat's result is loaded into the output register when the engine
//   pops the beat from the queue; one beat per cycle is sustained while
//   out_ready_i is high.
// reset: sequencer idle, output register cleared with no result valid,
//   registers at defaults, queue empty.
// stall: while out_ready_i is low the result is held; the two-entry queue
//   keeps taking beats until full, then in_ready_o drops.
// ----------------------------------------------------------------------------
module i2c_master_register_read_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  reg_addr_i,
  input  logic [7:0]  read_length_i,
  input  logic        sda_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_level_o,
  output logic        sda_release_o,
  output logic        data_valid_o,
  output logic [7:0]  read_byte_o,
  output logic        last_byte_o,
  output logic        busy_res_o,
  output logic        error_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  i2cmrr_pkg::cfg_t    cfg_q;
  i2cmrr_pkg::item_t   q_item;
  i2cmrr_pkg::result_t result;
  logic                q_valid;
  logic                q_pop;
  logic                cfg_we;
  logic [1:0]          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= i2cmrr_pkg::DEVICE_ADDRESS_RST;
      cfg_q.ack_timeout_limit <= i2cmrr_pkg::ACK_TIMEOUT_RST;
      cfg_q.bit_phase_ticks   <= i2cmrr_pkg::BIT_PHASE_RST;
      cfg_q.start_stop_ticks  <= i2cmrr_pkg::START_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        i2cmrr_pkg::REG_DEVICE_ADDRESS: cfg_q.device_address    <= pwdata[6:0];
        i2cmrr_pkg::REG_ACK_TIMEOUT:    cfg_q.ack_timeout_limit <= pwdata[7:0];
        i2cmrr_pkg::REG_BIT_PHASE:      cfg_q.bit_phase_ticks   <= pwdata[3:0];
        i2cmrr_pkg::REG_START_STOP:     cfg_q.start_stop_ticks  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      i2cmrr_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, cfg_q.device_address};
      i2cmrr_pkg::REG_ACK_TIMEOUT:    prdata = {24'd0, cfg_q.ack_timeout_limit};
      i2cmrr_pkg::REG_BIT_PHASE:      prdata = {28'd0, cfg_q.bit_phase_ticks};
      i2cmrr_pkg::REG_START_STOP:     prdata = {28'd0, cfg_q.start_stop_ticks};
      default:                        prdata = 32'd0;
    endcase
  end

  // front: accept and queue
  i2cmrr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .reg_addr_i    (reg_addr_i),
    .read_length_i (read_length_i),
    .sda_in_i      (sda_in_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  // back: bus sequencer
  i2cmrr_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign scl_level_o   = result.scl_level;
  assign sda_release_o = result.sda_release;
  assign data_valid_o  = result.data_valid;
  assign read_byte_o   = result.read_byte;
  assign last_byte_o   = result.last_byte;
  assign busy_res_o    = result.busy_res;
  assign error_o       = result.error;

endmodule

### hdl/i2cmrr_checker.sv
// ----------------------------------------------------------------------------
// i2cmrr_checker
// port-level checks of the i2c master register read core
// ----------------------------------------------------------------------------
module i2cmrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        scl_level_o,
  input logic        sda_release_o,
  input logic        data_valid_o,
  input logic [7:0]  read_byte_o,
  input logic        last_byte_o,
  input logic        busy_res_o,
  input logic        error_o
);

  // a stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_byte_o)
      && $stable(data_valid_o) && $stable(busy_res_o))
    else $error("result beat dropped or changed under stall");

  // a received byte only appears mid transaction
  a_byte_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && data_valid_o |-> busy_res_o)
    else $error("byte presented while idle");

  // last marker only comes with a byte
  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o |-> data_valid_o)
    else $error("last marker without a byte");

  // idle releases both lines and shows no byte
  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> scl_level_o && sda_release_o && !data_valid_o)
    else $error("lines not released while idle");

  // an abort ends through a stop so error never shows mid byte reception
  a_error_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> !data_valid_o)
    else $error("byte presented after abort");

endmodule

bind i2c_master_register_read_core i2cmrr_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .scl_level_o   (scl_level_o),
  .sda_release_o (sda_release_o),
  .data_valid_o  (data_valid_o),
  .read_byte_o   (read_byte_o),
  .last_byte_o   (last_byte_o),
  .busy_res_o    (busy_res_o),
  .error_o       (error_o)
);

### verif/tb_i2c_master_register_read_core.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_register_read_core
// self-checking bench for the i2c master register read engine
// ----------------------------------------------------------------------------
// Drives start and tick beats into the core. A cycle-free model of the bus
// sequencer runs beside it and works out the SCL/SDA levels, received bytes,
// busy and error for each beat. A separate process compares every result
// beat with the oldest expectation. Both channels idle and stall at random.
// The configuration port is written between transfers and read back.
// Directed transfers cover the corners. Random traffic then runs under
// several register settings.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_read_core;

  localparam int ClkPeriod   = 12;
  localparam int ResetCycles = 12;
  localparam int LimitCycles = 2_000_000;
  localparam int DrainCycles = 8;

  // sequencer phases, in the order the engine walks them
  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_SETUP,
    PH_START_HOLD,
    PH_DEV_LOW,
    PH_DEV_HIGH,
    PH_REG_LOW,
    PH_REG_HIGH,
    PH_DEV_ACK_LOW,
    PH_DEV_ACK_HIGH,
    PH_REG_ACK_LOW,
    PH_REG_ACK_HIGH,
    PH_RESTART_LOW,
    PH_RX_LOW,
    PH_RX_HIGH,
    PH_MACK_LOW,
    PH_MACK_HIGH,
    PH_STOP_LOW,
    PH_STOP_CLK,
    PH_STOP_REL
  } phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        req_type_i;
  logic [7:0]  reg_addr_i;
  logic [7:0]  read_length_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        scl_level_o;
  logic        sda_release_o;
  logic        data_valid_o;
  logic [7:0]  read_byte_o;
  logic        last_byte_o;
  logic        busy_res_o;
  logic        error_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // engine model state and its copy of the registers
  phase_e           eng_phase;
  logic [3:0]       eng_ticks;
  logic [3:0]       eng_bits;
  logic [7:0]       eng_shift;
  logic [7:0]       eng_left;
  logic [7:0]       eng_reg;
  logic [7:0]       eng_ack_wait;
  logic             eng_err;
  logic             eng_read_pass;
  i2cmrr_pkg::cfg_t cfg;

  i2cmrr_pkg::result_t pending_levels[$];
  int                  mismatch_count;
  bit                  in_burst;

  i2c_master_register_read_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .reg_addr_i    (reg_addr_i),
    .read_length_i (read_length_i),
    .sda_in_i      (sda_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_level_o   (scl_level_o),
    .sda_release_o (sda_release_o),
    .data_valid_o  (data_valid_o),
    .read_byte_o   (read_byte_o),
    .last_byte_o   (last_byte_o),
    .busy_res_o    (busy_res_o),
    .error_o       (error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(ClkPeriod * LimitCycles);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // engine model
  // ---------------------------------------------------------------------------

  function automatic void reset_engine();
    eng_phase     = PH_IDLE;
    eng_ticks     = 4'd0;
    eng_bits      = 4'd0;
    eng_shift     = 8'd0;
    eng_left      = 8'd0;
    eng_reg       = 8'd0;
    eng_ack_wait  = 8'd0;
    eng_err       = 1'b0;
    eng_read_pass = 1'b0;
    cfg.device_address    = i2cmrr_pkg::DEVICE_ADDRESS_RST;
    cfg.ack_timeout_limit = i2cmrr_pkg::ACK_TIMEOUT_RST;
    cfg.bit_phase_ticks   = i2cmrr_pkg::BIT_PHASE_RST;
    cfg.start_stop_ticks  = i2cmrr_pkg::START_STOP_RST;
  endfunction

  function automatic void goto_phase(input phase_e nxt);
    eng_phase = nxt;
    eng_ticks = 4'd0;
  endfunction

  // count one tick of a timed phase, a zero length counts as one tick
  function automatic bit phase_elapsed(input logic [3:0] len);
    logic [3:0] span;
    span = (len == 4'd0) ? 4'd1 : len;
    eng_ticks = eng_ticks + 4'd1;
    if (eng_ticks >= span) begin
      eng_ticks = 4'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // high sample while waiting for an acknowledge
  function automatic void ack_missing();
    if (eng_ack_wait >= cfg.ack_timeout_limit) begin
      eng_err = 1'b1;
      goto_phase(PH_STOP_LOW);
    end else begin
      eng_ack_wait = eng_ack_wait + 8'd1;
    end
  endfunction

  function automatic void start_rx_byte();
    eng_shift = 8'd0;
    eng_bits  = 4'd0;
    goto_phase(PH_RX_LOW);
  endfunction

  // apply one input beat and return the levels and status that follow it
  function automatic i2cmrr_pkg::result_t advance_engine(input i2cmrr_pkg::item_t it);
    i2cmrr_pkg::result_t r;
    r = '0;
    r.scl_level   = 1'b1;
    r.sda_release = 1'b1;
    if (it.kind == i2cmrr_pkg::REQ_START) begin
      // a start is taken only while idle
      if (eng_phase == PH_IDLE) begin
        eng_reg       = it.reg_addr;
        eng_left      = it.read_length;
        eng_err       = 1'b0;
        eng_read_pass = 1'b0;
        eng_bits      = 4'd0;
        eng_shift     = 8'd0;
        eng_ack_wait  = 8'd0;
        goto_phase(PH_START_SETUP);
      end
    end else begin
      case (eng_phase)
        PH_START_SETUP: begin
          if (phase_elapsed(cfg.start_stop_ticks)) goto_phase(PH_START_HOLD);
        end
        PH_START_HOLD: begin
          if (phase_elapsed(cfg.start_stop_ticks)) begin
            eng_shift = {cfg.device_address, eng_read_pass};
            eng_bits  = 4'd0;
            goto_phase(PH_DEV_LOW);
          end
        end
        PH_DEV_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_DEV_HIGH);
        end
        PH_REG_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_REG_HIGH);
        end
        // address bits shift out msb first
        PH_DEV_HIGH, PH_REG_HIGH: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) begin
            eng_shift = eng_shift << 1;
            eng_bits  = eng_bits + 4'd1;
            if (eng_bits >= 4'd8) begin
              goto_phase(eng_phase == PH_DEV_HIGH ? PH_DEV_ACK_LOW : PH_REG_ACK_LOW);
              eng_bits     = 4'd0;
              eng_ack_wait = 8'd0;
            end else begin
              goto_phase(eng_phase == PH_DEV_HIGH ? PH_DEV_LOW : PH_REG_LOW);
            end
          end
        end
        PH_DEV_ACK_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_DEV_ACK_HIGH);
        end
        PH_REG_ACK_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_REG_ACK_HIGH);
        end
        // device ack: next comes the register, the stop or the first byte
        PH_DEV_ACK_HIGH: begin
          if (it.sda_in == 1'b0) begin
            if (!eng_read_pass) begin
              eng_shift = eng_reg;
              eng_bits  = 4'd0;
              goto_phase(PH_REG_LOW);
            end else if (eng_left == 8'd0) begin
              goto_phase(PH_STOP_LOW);
            end else begin
              start_rx_byte();
            end
          end else begin
            ack_missing();
          end
        end
        PH_REG_ACK_HIGH: begin
          if (it.sda_in == 1'b0) begin
            eng_read_pass = 1'b1;
            goto_phase(PH_RESTART_LOW);
          end else begin
            ack_missing();
          end
        end
        PH_RESTART_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_START_SETUP);
        end
        PH_RX_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_RX_HIGH);
        end
        // data sampled on the first tick of scl high
        PH_RX_HIGH: begin
          if (eng_ticks == 4'd0) eng_shift = {eng_shift[6:0], it.sda_in};
          if (phase_elapsed(cfg.bit_phase_ticks)) begin
            eng_bits = eng_bits + 4'd1;
            if (eng_bits >= 4'd8) begin
              r.data_valid = 1'b1;
              r.read_byte  = eng_shift;
              r.last_byte  = (eng_left <= 8'd1);
              eng_bits     = 4'd0;
              goto_phase(PH_MACK_LOW);
            end else begin
              goto_phase(PH_RX_LOW);
            end
          end
        end
        PH_MACK_LOW: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) goto_phase(PH_MACK_HIGH);
        end
        PH_MACK_HIGH: begin
          if (phase_elapsed(cfg.bit_phase_ticks)) begin
            if (eng_left != 8'd0) eng_left = eng_left - 8'd1;
            if (eng_left == 8'd0) goto_phase(PH_STOP_LOW);
            else start_rx_byte();
          end
        end
        PH_STOP_LOW: begin
          if (phase_elapsed(cfg.start_stop_ticks)) goto_phase(PH_STOP_CLK);
        end
        PH_STOP_CLK: begin
          if (phase_elapsed(cfg.start_stop_ticks)) goto_phase(PH_STOP_REL);
        end
        PH_STOP_REL: begin
          if (phase_elapsed(cfg.start_stop_ticks)) goto_phase(PH_IDLE);
        end
        default: begin
          goto_phase(PH_IDLE);
        end
      endcase
    end

    // bus levels of the phase now entered
    case (eng_phase)
      PH_START_HOLD: r.sda_release = 1'b0;
      PH_DEV_LOW, PH_REG_LOW: begin
        r.scl_level   = 1'b0;
        r.sda_release = eng_shift[7];
      end
      PH_DEV_HIGH, PH_REG_HIGH: r.sda_release = eng_shift[7];
      PH_DEV_ACK_LOW, PH_REG_ACK_LOW, PH_RESTART_LOW, PH_RX_LOW: r.scl_level = 1'b0;
      PH_MACK_LOW: begin
        r.scl_level   = 1'b0;
        r.sda_release = (eng_left <= 8'd1);
      end
      PH_MACK_HIGH: r.sda_release = (eng_left <= 8'd1);
      PH_STOP_LOW: begin
        r.scl_level   = 1'b0;
        r.sda_release = 1'b0;
      end
      PH_STOP_CLK: r.sda_release = 1'b0;
      default: ;
    endcase
    r.busy_res = (eng_phase != PH_IDLE);
    r.error    = eng_err;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // input channel
  // ---------------------------------------------------------------------------

  // one input beat, predicted when it is taken
  task automatic send_beat(input i2cmrr_pkg::req_e kind, input logic [7:0] reg_a,
                           input logic [7:0] len, input logic sda);
    int                gap;
    i2cmrr_pkg::item_t it;
    it.kind        = kind;
    it.reg_addr    = reg_a;
    it.read_length = len;
    it.sda_in      = sda;
    if ($urandom_range(49) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    reg_addr_i    <= reg_a;
    read_length_i <= len;
    sda_in_i      <= sda;
    do @(posedge clk_i); while (!in_ready_o);
    pending_levels.push_back(advance_engine(it));
  endtask

  task automatic send_tick(input logic sda);
    send_beat(i2cmrr_pkg::REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), sda);
  endtask

  // target response on sda: acknowledges by chance, other phases random
  function automatic logic bus_sda(input int dev_pct, input int reg_pct);
    case (eng_phase)
      PH_DEV_ACK_HIGH: return ($urandom_range(99) < dev_pct) ? 1'b0 : 1'b1;
      PH_REG_ACK_HIGH: return ($urandom_range(99) < reg_pct) ? 1'b0 : 1'b1;
      default:         return 1'($urandom_range(1));
    endcase
  endfunction

  task automatic run_to_idle(input int dev_pct, input int reg_pct);
    while (eng_phase != PH_IDLE) send_tick(bus_sda(dev_pct, reg_pct));
  endtask

  task automatic run_read(input logic [7:0] reg_a, input logic [7:0] len,
                          input int dev_pct, input int reg_pct);
    send_beat(i2cmrr_pkg::REQ_START, reg_a, len, 1'($urandom_range(1)));
    run_to_idle(dev_pct, reg_pct);
  endtask

  // drop valid and let every result come back
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] reg_mask(input logic [1:0] idx);
    case (idx)
      i2cmrr_pkg::REG_DEVICE_ADDRESS: return 32'h7F;
      i2cmrr_pkg::REG_ACK_TIMEOUT:    return 32'hFF;
      default:                        return 32'hF;
    endcase
  endfunction

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    logic [31:0] mask;
    mask = reg_mask(idx);
    apb_access(1'b0, idx, 32'd0, got);
    if ((got & mask) != (want & mask)) begin
      $display("%0t: register %0d readback expected %0h actual %0h",
               $time, idx, want & mask, got & mask);
      mismatch_count++;
    end
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, value, unused);
    case (idx)
      i2cmrr_pkg::REG_DEVICE_ADDRESS: cfg.device_address    = value[6:0];
      i2cmrr_pkg::REG_ACK_TIMEOUT:    cfg.ack_timeout_limit = value[7:0];
      i2cmrr_pkg::REG_BIT_PHASE:      cfg.bit_phase_ticks   = value[3:0];
      default:                        cfg.start_stop_ticks  = value[3:0];
    endcase
    check_reg(idx, value);
  endtask

  task automatic apply_config(input logic [6:0] dev, input logic [7:0] limit,
                              input logic [3:0] bit_len, input logic [3:0] ss_len);
    program_reg(i2cmrr_pkg::REG_DEVICE_ADDRESS, 32'(dev));
    program_reg(i2cmrr_pkg::REG_ACK_TIMEOUT, 32'(limit));
    program_reg(i2cmrr_pkg::REG_BIT_PHASE, 32'(bit_len));
    program_reg(i2cmrr_pkg::REG_START_STOP, 32'(ss_len));
  endtask

  // ---------------------------------------------------------------------------
  // output channel
  // ---------------------------------------------------------------------------

  // result sink with random stalls and calm stretches
  initial begin : result_sink
    int stall;
    bit calm;
    out_ready_i = 1'b0;
    calm        = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(49) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(8);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    i2cmrr_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: result beat with no expectation, expected none actual busy=%0b",
                 $time, busy_res_o);
        mismatch_count++;
      end else begin
        want = pending_levels.pop_front();
        compare_field("scl_level", want.scl_level, scl_level_o);
        compare_field("sda_release", want.sda_release, sda_release_o);
        compare_field("data_valid", want.data_valid, data_valid_o);
        compare_field("read_byte", want.read_byte, read_byte_o);
        compare_field("last_byte", want.last_byte, last_byte_o);
        compare_field("busy_res", want.busy_res, busy_res_o);
        compare_field("error", want.error, error_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values and ticks while idle
  task automatic test_register_reset();
    check_reg(i2cmrr_pkg::REG_DEVICE_ADDRESS, 32'(i2cmrr_pkg::DEVICE_ADDRESS_RST));
    check_reg(i2cmrr_pkg::REG_ACK_TIMEOUT, 32'(i2cmrr_pkg::ACK_TIMEOUT_RST));
    check_reg(i2cmrr_pkg::REG_BIT_PHASE, 32'(i2cmrr_pkg::BIT_PHASE_RST));
    check_reg(i2cmrr_pkg::REG_START_STOP, 32'(i2cmrr_pkg::START_STOP_RST));
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  // full read with both address passes and repeated start, reset timing
  task automatic test_basic_read();
    run_read(8'hA5, 8'd1, 100, 100);
    settle();
  endtask

  // both address phases then straight to stop
  task automatic test_zero_length();
    apply_config(7'($urandom_range(127)), 8'd250, 4'd1, 4'd1);
    run_read(8'h00, 8'd0, 100, 100);
    settle();
  endtask

  // missing acknowledges abort with a stop and set the error
  task automatic test_ack_timeout();
    apply_config(7'($urandom_range(127)), 8'd0, 4'd1, 4'd1);
    run_read(8'h3C, 8'd1, 0, 100);
    run_read(8'hC3, 8'd1, 100, 0);
    settle();
    apply_config(7'($urandom_range(127)), 8'd40, 4'd1, 4'd2);
    run_read(8'h69, 8'd1, 0, 100);
    settle();
    apply_config(7'($urandom_range(127)), 8'd1, 4'd2, 4'd1);
    run_read(8'h11, 8'd3, 0, 100);
    settle();
  endtask

  // a start while busy is dropped
  task automatic test_start_while_busy();
    send_beat(i2cmrr_pkg::REQ_START, 8'h5A, 8'd0, 1'b1);
    repeat (10) send_tick(bus_sda(100, 100));
    send_beat(i2cmrr_pkg::REQ_START, 8'hFF, 8'd255, 1'b0);
    repeat (30) send_tick(bus_sda(100, 100));
    send_beat(i2cmrr_pkg::REQ_START, 8'h00, 8'd0, 1'b1);
    run_to_idle(100, 100);
    settle();
  endtask

  // several bytes, acked until the last one
  task automatic test_multi_byte_read();
    apply_config(7'h7F, 8'd250, 4'd1, 4'd1);
    run_read(8'hFF, 8'd3, 100, 100);
    settle();
  endtask

  // zero phase lengths behave as one tick
  task automatic test_zero_phase();
    apply_config(7'h00, 8'd3, 4'd0, 4'd0);
    run_read(8'h81, 8'd1, 100, 100);
    settle();
  endtask

  // slowest bit phases, cut short by a missing device acknowledge
  task automatic test_slow_phases();
    apply_config(7'h2A, 8'd0, 4'd15, 4'd1);
    run_read(8'hE7, 8'd1, 0, 100);
    settle();
  endtask

  function automatic logic [7:0] pick_length();
    if ($urandom_range(99) < 10) return 8'($urandom_range(6));
    return 8'($urandom_range(3));
  endfunction

  // mostly well-formed reads, some with missing acks, some stray starts
  task automatic random_reads(input int target);
    int counted;
    int ack_pct;
    counted = 0;
    ack_pct = 100;
    while (counted < target) begin
      if (eng_phase == PH_IDLE) begin
        if ($urandom_range(99) < 75) begin
          ack_pct = ($urandom_range(99) < 85) ? 97 : $urandom_range(60);
          send_beat(i2cmrr_pkg::REQ_START, 8'($urandom_range(255)), pick_length(),
                    1'($urandom_range(1)));
          counted++;
        end else begin
          send_tick(1'($urandom_range(1)));
        end
      end else if ($urandom_range(99) < 3) begin
        send_beat(i2cmrr_pkg::REQ_START, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_tick(bus_sda(ack_pct, ack_pct));
        counted++;
      end
    end
    run_to_idle(ack_pct, ack_pct);
  endtask

  task automatic test_random_traffic();
    logic [7:0] limit;
    logic [3:0] bit_len;
    logic [3:0] ss_len;
    for (int ph = 0; ph < 3; ph++) begin
      case ($urandom_range(3))
        0:       limit = 8'd0;
        1:       limit = 8'd1;
        2:       limit = 8'd255;
        default: limit = 8'($urandom_range(254, 2));
      endcase
      bit_len = (ph == 0) ? 4'd1 : 4'($urandom_range(3));
      ss_len  = (ph == 0) ? 4'd15 : 4'($urandom_range(3));
      apply_config(7'($urandom_range(127)), limit, bit_len, ss_len);
      random_reads(30);
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    req_type_i     = i2cmrr_pkg::REQ_TICK;
    reg_addr_i     = 8'd0;
    read_length_i  = 8'd0;
    sda_in_i       = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = 4'd0;
    pwdata         = 32'd0;
    mismatch_count = 0;
    in_burst       = 1'b0;
    reset_engine();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_basic_read();
    test_zero_length();
    test_start_while_busy();
    test_ack_timeout();
    test_multi_byte_read();
    test_zero_phase();
    test_slow_phases();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### i2c_master_register_read_core.f
hdl/i2cmrr_pkg.sv
hdl/i2cmrr_front.sv
hdl/i2cmrr_engine.sv
hdl/i2c_master_register_read_core.sv
hdl/i2cmrr_checker.sv
verif/tb_i2c_master_register_read_core.sv
